>>> hw/rtl/mh64_pkg.sv
package mh64_pkg;

  // Hash constants
  localparam logic [63:0] MIX_MUL   = 64'hC6A4_A793_5BD1_E995;
  localparam logic [63:0] HASH_SEED = 64'd3782874213;
  localparam int unsigned MIX_SHIFT = 47;

  // Partial product steps of the shared multiplier
  typedef enum logic [1:0] {
    MS_LL,   // low word times low constant word
    MS_LH,   // low word times high constant word
    MS_HL,   // high word times low constant word
    MS_ACC   // fold last cross product
  } mul_step_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_DATA,
    ST_KEY1,
    ST_KEY2,
    ST_HMUL,
    ST_FINAL,
    ST_FIN_MUL,
    ST_OUT
  } seq_state_e;

  // One input word request
  typedef struct packed {
    logic [31:0] message_length;
    logic        first_word;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } item_t;

  // Finished hash offered to the output stage
  typedef struct packed {
    logic        valid;
    logic [63:0] hash;
  } res_t;

  // Shift-xor step used by block mixing and finalization
  function automatic logic [63:0] xor_shift(input logic [63:0] x);
    return x ^ (x >> MIX_SHIFT);
  endfunction

endpackage

>>> hw/rtl/murmur64a_byte_hash_top.sv
// Channel | Handshake                  | Payload
// input   | in_valid_i / in_ready_o    | message_length_i, first_word_i, data_word_i,
//         |                            | valid_bytes_i, last_word_i
// output  | out_valid_o / out_ready_i  | hash_value_o
//
// One word at a time: the input is not ready again until the word is finished. A
// first word adds one 64-bit multiply, a full word three, a tail word one, a last
// word one. Each multiply is four steps (three 32x32 partial products and a fold)
// on one shared multiplier. Reset (rst_ni, async, low) clears the running hash to
// zero. A held output only stalls the block once a new hash is ready and the
// output register is still full.
module murmur64a_byte_hash_top import mh64_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] message_length_i,
  input  logic        first_word_i,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_value_o
);

  item_t       req;
  res_t        res;
  logic        res_ready;
  logic        out_valid_q;
  logic [63:0] hash_q;

  // Pack the input request
  assign req.message_length = message_length_i;
  assign req.first_word     = first_word_i;
  assign req.data_word      = data_word_i;
  assign req.valid_bytes    = valid_bytes_i;
  assign req.last_word      = last_word_i;

  mh64_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (req),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  // Load the output register or drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      hash_q <= res.hash;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

endmodule

>>> hw/rtl/mh64_mul.sv
module mh64_mul import mh64_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  output logic        done_o,
  output logic [63:0] p_o
);

  logic [63:0] a_q;
  logic [63:0] prod_q;
  logic [63:0] acc_q;
  mul_step_e   step_q;
  logic        busy_q;
  logic        done_q;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] mul_res;

  // Select the 32-bit halves for the current partial product
  always_comb begin
    op_a    = (step_q == MS_HL) ? a_q[63:32] : a_q[31:0];
    op_b    = (step_q == MS_LH) ? MIX_MUL[63:32] : MIX_MUL[31:0];
    mul_res = 64'(op_a) * 64'(op_b);
  end

  // Advance the step counter and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= MS_LL;
    end else begin
      done_q <= busy_q && (step_q == MS_ACC);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= MS_LL;
      end else if (busy_q) begin
        unique case (step_q)
          MS_LL:   step_q <= MS_LH;
          MS_LH:   step_q <= MS_HL;
          MS_HL:   step_q <= MS_ACC;
          MS_ACC:  busy_q <= 1'b0;
          default: busy_q <= 1'b0;
        endcase
      end
    end
  end

  // Register each partial product, then fold it into the low 64 bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
    end
    if (busy_q) begin
      prod_q <= mul_res;
      case (step_q)
        MS_LH:   acc_q <= prod_q;
        MS_HL:   acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
        MS_ACC:  acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
        default: acc_q <= acc_q;
      endcase
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

>>> hw/rtl/mh64_core.sv
module mh64_core import mh64_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  input  item_t req_i,
  output res_t  res_o,
  input  logic  res_ready_i
);

  seq_state_e  state_q, state_d;
  item_t       item_q, item_d;
  logic [63:0] h_q, h_d;
  logic [63:0] res_hash_q, res_hash_d;
  logic        mul_start;
  logic [63:0] mul_a;
  logic        mul_done;
  logic [63:0] mul_p;
  logic [63:0] tail_h;

  // Keep the low n bytes of a word
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = {8{4'(i) < n}};
    end
    return m;
  endfunction

  mh64_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  assign tail_h = h_q ^ (item_q.data_word & byte_mask(item_q.valid_bytes));

  // Sequence the multiplies of one word
  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    h_d        = h_q;
    res_hash_d = res_hash_q;
    mul_start  = 1'b0;
    mul_a      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          item_d = req_i;
          if (req_i.first_word) begin
            mul_start = 1'b1;
            mul_a     = {32'd0, req_i.message_length};
            state_d   = ST_SEED;
          end else begin
            state_d = ST_DATA;
          end
        end
      end
      ST_SEED: begin
        if (mul_done) begin
          h_d     = HASH_SEED ^ mul_p;
          state_d = ST_DATA;
        end
      end
      ST_DATA: begin
        if (item_q.valid_bytes[3]) begin
          mul_start = 1'b1;
          mul_a     = item_q.data_word;
          state_d   = ST_KEY1;
        end else if (item_q.valid_bytes != 4'd0) begin
          h_d       = tail_h;
          mul_start = 1'b1;
          mul_a     = tail_h;
          state_d   = ST_HMUL;
        end else begin
          state_d = ST_FINAL;
        end
      end
      ST_KEY1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = xor_shift(mul_p);
          state_d   = ST_KEY2;
        end
      end
      ST_KEY2: begin
        if (mul_done) begin
          h_d       = h_q ^ mul_p;
          mul_start = 1'b1;
          mul_a     = h_q ^ mul_p;
          state_d   = ST_HMUL;
        end
      end
      ST_HMUL: begin
        if (mul_done) begin
          h_d     = mul_p;
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (item_q.last_word) begin
          mul_start = 1'b1;
          mul_a     = xor_shift(h_q);
          state_d   = ST_FIN_MUL;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FIN_MUL: begin
        if (mul_done) begin
          res_hash_d = xor_shift(mul_p);
          state_d    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state and running hash
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      h_q     <= '0;
    end else begin
      state_q <= state_d;
      h_q     <= h_d;
    end
  end

  // Hold captured request and finished hash
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    res_hash_q <= res_hash_d;
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_o.valid = (state_q == ST_OUT);
  assign res_o.hash  = res_hash_q;

endmodule

>>> hw/rtl/mh64_checker.sv
module mh64_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [31:0] message_length_i,
  input logic        first_word_i,
  input logic [63:0] data_word_i,
  input logic [3:0]  valid_bytes_i,
  input logic        last_word_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] hash_value_o
);

  // Hold a result until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  // Go busy right after taking a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one in work");

  // A new result never appears while the block was idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without work in progress");

  // An empty middle word passes through ST_DATA and ST_FINAL and returns to ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !first_word_i && !last_word_i && (valid_bytes_i == 4'd0)
    |-> ##3 in_ready_o)
    else $error("empty word did not finish in three cycles");

endmodule

bind murmur64a_byte_hash_top mh64_checker u_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam logic [63:0] MULT        = 64'hC6A4_A793_5BD1_E995;
  localparam logic [63:0] SEED        = 64'd3782874213;
  localparam int          XS_SHIFT    = 47;
  localparam int          WORDS_TOTAL = 524;
  localparam int          PAUSE_AT    = 250;
  localparam int          QUIET_FROM  = 440;
  localparam int          DRAIN_WAIT  = 64;
  localparam int          CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [31:0] msg_len;
    logic        first;
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
  } hash_word_t;

  typedef struct packed {
    hash_word_t  w;
    logic        known;
    logic [63:0] known_hash;
  } plan_row_t;

  logic        clk_i;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic [31:0] message_length_i = '0;
  logic        first_word_i     = 1'b0;
  logic [63:0] data_word_i      = '0;
  logic [3:0]  valid_bytes_i    = '0;
  logic        last_word_i      = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic [63:0] hash_value_o;

  logic [63:0] mix_state = '0;
  logic [63:0] hash_queue [$];
  plan_row_t   plan [$];
  int          words_sent  = 0;
  int          fail_count  = 0;
  int          cycle_count = 0;
  bit          idle_on     = 1'b1;

  murmur64a_byte_hash_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .message_length_i (message_length_i),
    .first_word_i     (first_word_i),
    .data_word_i      (data_word_i),
    .valid_bytes_i    (valid_bytes_i),
    .last_word_i      (last_word_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hash_value_o     (hash_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Fold one word into the running hash; return 1 with the finished hash on a last word
  function automatic bit absorb_word(input hash_word_t w, output logic [63:0] digest);
    logic [63:0] k;
    logic [63:0] keep;
    logic [63:0] h;
    if (w.first) begin
      mix_state = SEED ^ ({32'd0, w.msg_len} * MULT);
    end
    if (w.nbytes >= 4'd8) begin
      k = w.data * MULT;
      k = k ^ (k >> XS_SHIFT);
      k = k * MULT;
      mix_state = (mix_state ^ k) * MULT;
    end else if (w.nbytes != 4'd0) begin
      keep = (64'd1 << (8 * w.nbytes)) - 64'd1;
      mix_state = (mix_state ^ (w.data & keep)) * MULT;
    end
    h = mix_state;
    h = h ^ (h >> XS_SHIFT);
    h = h * MULT;
    digest = h ^ (h >> XS_SHIFT);
    return w.last;
  endfunction

  function automatic void note_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] %s: expected %016h, got %016h", $time, what, want, got);
    end
  endfunction

  // Offer one request, hold it until accepted, then predict its hash
  task automatic send_word(input hash_word_t w, input logic known,
                           input logic [63:0] known_hash);
    logic [63:0] digest;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    message_length_i <= w.msg_len;
    first_word_i     <= w.first;
    data_word_i      <= w.data;
    valid_bytes_i    <= w.nbytes;
    last_word_i      <= w.last;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    if (absorb_word(w, digest)) begin
      hash_queue.push_back(known ? known_hash : digest);
    end
  endtask

  // Split a message of total bytes into words; close marks the final word as last
  task automatic send_message(input logic [31:0] declared, input int total, input bit close);
    hash_word_t w;
    int         left;
    bit         opening;
    left    = total;
    opening = 1'b1;
    do begin
      w.msg_len = opening ? declared : $urandom;
      w.first   = opening;
      w.data    = {$urandom, $urandom};
      w.nbytes  = (left >= 8) ? 4'd8 : 4'(left);
      w.last    = close && (left <= 8);
      send_word(w, 1'b0, '0);
      left    = left - int'(w.nbytes);
      opening = 1'b0;
    end while (left > 0);
  endtask

  task automatic plan_row(input logic [31:0] len, input logic first, input logic [63:0] data,
                          input logic [3:0] nbytes, input logic last, input logic known,
                          input logic [63:0] known_hash);
    plan.push_back('{'{len, first, data, nbytes, last}, known, known_hash});
  endtask

  // Randomly stall the result side in short bursts
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Compare each accepted hash with the oldest prediction
  always @(posedge clk_i) begin : check_hash
    logic [63:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (hash_queue.size() == 0) begin
        note_mismatch("unexpected hash", '0, hash_value_o);
      end else begin
        want = hash_queue.pop_front();
        if (want !== hash_value_o) begin
          note_mismatch("hash_value", want, hash_value_o);
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    hash_word_t w;
    int         pick;
    int         total;
    bit         pause_done;
    pause_done = 1'b0;

    // Directed requests: len, first, data, valid bytes, last, known, known hash
    // Zero state with no data finalizes to zero
    plan_row(32'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, 1'b1, 64'd0);
    // Empty message
    plan_row(32'd0, 1'b1, 64'h0, 4'd0, 1'b1, 1'b0, '0);
    // Single full block
    plan_row(32'd8, 1'b1, 64'h0123_4567_89AB_CDEF, 4'd8, 1'b1, 1'b0, '0);
    // Largest length, zero block, count above eight as full block, all-ones tail
    plan_row(32'hFFFF_FFFF, 1'b1, 64'h0, 4'd8, 1'b0, 1'b0, '0);
    plan_row(32'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 1'b0, '0);
    plan_row(32'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 1'b1, 1'b0, '0);
    // Bytes beyond the count are ignored
    plan_row(32'd3, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 1'b1, 1'b0, '0);
    plan_row(32'd9, 1'b1, 64'hA5A5_A5A5_A5A5_A5A5, 4'd9, 1'b1, 1'b0, '0);
    // Every tail size as a one-word message
    plan_row(32'd1, 1'b1, 64'hFEDC_BA98_7654_3210, 4'd1, 1'b1, 1'b0, '0);
    plan_row(32'd2, 1'b1, 64'hFEDC_BA98_7654_3210, 4'd2, 1'b1, 1'b0, '0);
    plan_row(32'd3, 1'b1, 64'hFEDC_BA98_7654_3210, 4'd3, 1'b1, 1'b0, '0);
    plan_row(32'd4, 1'b1, 64'hFEDC_BA98_7654_3210, 4'd4, 1'b1, 1'b0, '0);
    plan_row(32'd5, 1'b1, 64'hFEDC_BA98_7654_3210, 4'd5, 1'b1, 1'b0, '0);
    plan_row(32'd6, 1'b1, 64'hFEDC_BA98_7654_3210, 4'd6, 1'b1, 1'b0, '0);
    plan_row(32'd7, 1'b1, 64'hFEDC_BA98_7654_3210, 4'd7, 1'b1, 1'b0, '0);
    // Tail in the middle of a message
    plan_row(32'd20, 1'b1, 64'h1122_3344_5566_7788, 4'd3, 1'b0, 1'b0, '0);
    plan_row(32'd0, 1'b0, 64'h99AA_BBCC_DDEE_FF00, 4'd8, 1'b0, 1'b0, '0);
    plan_row(32'd0, 1'b0, 64'h0F0F_0F0F_0F0F_0F0F, 4'd1, 1'b1, 1'b0, '0);
    // Declared length disagrees with the data
    plan_row(32'd3, 1'b1, 64'h8000_0000_0000_0001, 4'd8, 1'b1, 1'b0, '0);
    // Continue after a result without a first word
    plan_row(32'd0, 1'b0, 64'h7777_6666_5555_4444, 4'd5, 1'b1, 1'b0, '0);
    // First word with no data, two blocks, empty last word
    plan_row(32'd16, 1'b1, 64'hDEAD_BEEF_CAFE_F00D, 4'd0, 1'b0, 1'b0, '0);
    plan_row(32'd0, 1'b0, 64'h0123_4567_89AB_CDEF, 4'd8, 1'b0, 1'b0, '0);
    plan_row(32'd0, 1'b0, 64'hFEDC_BA98_7654_3210, 4'd8, 1'b0, 1'b0, '0);
    plan_row(32'd0, 1'b0, 64'h0, 4'd0, 1'b1, 1'b0, '0);

    // Hold reset, then release
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      send_word(plan[i].w, plan[i].known, plan[i].known_hash);
    end

    // Random traffic: mostly well-formed messages, some noise and broken messages
    while (words_sent < WORDS_TOTAL) begin
      idle_on = (words_sent < 150) || (words_sent >= 300 && words_sent < QUIET_FROM);
      if (!pause_done && words_sent >= PAUSE_AT) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (hash_queue.size() != 0);
        pause_done = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        w.msg_len = $urandom;
        w.first   = 1'($urandom_range(0, 1));
        w.data    = {$urandom, $urandom};
        w.nbytes  = 4'($urandom_range(0, 15));
        w.last    = 1'($urandom_range(0, 1));
        send_word(w, 1'b0, '0);
      end else if (pick == 1) begin
        send_message($urandom, $urandom_range(0, 30), 1'($urandom_range(0, 1)));
      end else begin
        total = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160) : $urandom_range(0, 40);
        send_message(32'(total), total, 1'b1);
      end
    end

    // Drain outstanding hashes
    in_valid_i <= 1'b0;
    while (hash_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
